// ===== rtl/lossless_predictor_min_select_defines.svh =====
// ----------------------------------------------------------------------------
// lossless predictor min select: assertion macros
// Shared assertion wrappers, clocked on clk, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef LOSSLESS_PREDICTOR_MIN_SELECT_DEFINES_SVH
`define LOSSLESS_PREDICTOR_MIN_SELECT_DEFINES_SVH

// property checked outside reset
`define LPMS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every edge, reset included
`define LPMS_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/lpms_pkg.sv =====
// ----------------------------------------------------------------------------
// lpms_pkg
// Types, constants and helpers shared by the predictor lanes, merge and top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpms_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int NUM_PRED   = 7;
  localparam int NUM_CH     = 3;
  localparam int CH_W       = 8;
  localparam int PV_W       = 10;           // signed predictor value, -255..510
  localparam int SUM_W      = 12;           // signed sum of three channels
  localparam int MAG_W      = SUM_W - 1;
  localparam int RECIP_W    = 16;
  localparam int PROD_W     = MAG_W + RECIP_W;
  localparam int RECIP_SH   = 17;
  localparam logic [RECIP_W-1:0] RECIP3 = 16'd43691;  // (2^17 + 1) / 3

  localparam int CFG_WIDTH_W  = 13;
  localparam int CFG_HEIGHT_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = 16'd480;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PRED_A     = 3'd0,
    PRED_B     = 3'd1,
    PRED_C     = 3'd2,
    PRED_ABC   = 3'd3,
    PRED_A_HBC = 3'd4,
    PRED_B_HAC = 3'd5,
    PRED_AVG   = 3'd6
  } pred_sel_t;

  typedef struct packed {
    logic [CH_W-1:0] in_ch2;
    logic [CH_W-1:0] in_ch1;
    logic [CH_W-1:0] in_ch0;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0] pred_ch2;
    logic [CH_W-1:0] pred_ch1;
    logic [CH_W-1:0] pred_ch0;
  } res_t;

  typedef logic signed [PV_W-1:0]  pval_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // load strobes of the two lane stages
  typedef struct packed {
    logic ld2;
    logic ld3;
  } adv_t;

  function automatic logic [CH_W-1:0] chan_of(pix_t px, logic [1:0] k);
    logic [CH_W-1:0] v;
    case (k)
      2'd0:    v = px.in_ch0;
      2'd1:    v = px.in_ch1;
      2'd2:    v = px.in_ch2;
      default: v = px.in_ch0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/lpms_row_mem.sv =====
// ----------------------------------------------------------------------------
// lpms_row_mem
// Previous-row pixel store, one read-before-write port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpms_row_mem import lpms_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [COL_W-1:0] addr,
  input  pix_t             wdata,
  output pix_t             rdata
);

  pix_t mem [MAX_WIDTH];

  // old entry is read out while the new pixel replaces it
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

// ===== rtl/lpms_lane.sv =====
// ----------------------------------------------------------------------------
// lpms_lane
// One predictor for all three channels, its channel sum and the mean by three.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpms_lane import lpms_pkg::*; (
  input  logic      clk,
  input  pred_sel_t idx,
  input  adv_t      adv,
  input  pix_t      left,
  input  pix_t      above,
  input  pix_t      upleft,
  output pval_t     pred [NUM_CH],
  output pval_t     mean
);

  pval_t             pv [NUM_CH];
  pval_t             pv2 [NUM_CH];
  sum_t              sum_c;
  sum_t              sum2;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [PV_W-1:0]   quo;
  pval_t             mean_c;

  always_comb begin
    pval_t a, b, c, d_bc, d_ac, h_bc, h_ac;
    for (int k = 0; k < NUM_CH; k++) begin
      a    = pval_t'(PV_W'(chan_of(left, 2'(k))));
      b    = pval_t'(PV_W'(chan_of(above, 2'(k))));
      c    = pval_t'(PV_W'(chan_of(upleft, 2'(k))));
      d_bc = b - c;
      d_ac = a - c;
      // halve, rounding toward zero
      h_bc = (d_bc + $signed({{(PV_W-1){1'b0}}, d_bc[PV_W-1]})) >>> 1;
      h_ac = (d_ac + $signed({{(PV_W-1){1'b0}}, d_ac[PV_W-1]})) >>> 1;
      case (idx)
        PRED_A:     pv[k] = a;
        PRED_B:     pv[k] = b;
        PRED_C:     pv[k] = c;
        PRED_ABC:   pv[k] = a + b - c;
        PRED_A_HBC: pv[k] = a + h_bc;
        PRED_B_HAC: pv[k] = b + h_ac;
        PRED_AVG:   pv[k] = (a + b) >>> 1;
        default:    pv[k] = a;
      endcase
    end
    sum_c = SUM_W'(pv[0]) + SUM_W'(pv[1]) + SUM_W'(pv[2]);
  end

  // mean by three: magnitude times reciprocal, sign restored
  always_comb begin
    mag    = sum2[SUM_W-1] ? MAG_W'(-sum2) : MAG_W'(sum2);
    prod   = PROD_W'(mag) * PROD_W'(RECIP3);
    quo    = PV_W'(prod >> RECIP_SH);
    mean_c = sum2[SUM_W-1] ? pval_t'(-quo) : pval_t'(quo);
  end

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      pv2  <= pv;
      sum2 <= sum_c;
    end
    if (adv.ld3) begin
      pred <= pv2;
      mean <= mean_c;
    end
  end

endmodule

// ===== rtl/lpms_merge.sv =====
// ----------------------------------------------------------------------------
// lpms_merge
// Picks the lane with the smallest mean, lowest index on a tie, and registers
// the result word; border pixels take the input word instead.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpms_merge import lpms_pkg::*; (
  input  logic  clk,
  input  logic  ld,
  input  pix_t  cur,
  input  logic  border,
  input  pval_t mean [NUM_PRED],
  input  pval_t pred [NUM_PRED][NUM_CH],
  output res_t  res
);

  logic [2:0] sel;
  res_t       res_c;

  always_comb begin
    pval_t best;
    best = mean[0];
    sel  = 3'd0;
    for (int i = 1; i < NUM_PRED; i++) begin
      if (mean[i] < best) begin
        best = mean[i];
        sel  = 3'(i);
      end
    end
    if (border) begin
      res_c.pred_ch0 = cur.in_ch0;
      res_c.pred_ch1 = cur.in_ch1;
      res_c.pred_ch2 = cur.in_ch2;
    end else begin
      res_c.pred_ch0 = pred[sel][0][CH_W-1:0];
      res_c.pred_ch1 = pred[sel][1][CH_W-1:0];
      res_c.pred_ch2 = pred[sel][2][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res <= res_c;
    end
  end

endmodule

// ===== rtl/lossless_predictor_min_select.sv =====
// ----------------------------------------------------------------------------
// lossless_predictor_min_select: accepted pixel passes stages one to three, then output
// one pixel per clock unless stalled, four stages each with its own valid bit
// sync reset empties the pipeline, clears counters, sets width 640 height 480
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lossless_predictor_min_select_defines.svh"

module lossless_predictor_min_select import lpms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  pix_t                  pix,
  output logic                  pred_valid,
  input  logic                  pred_stall,
  output res_t                  pred,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WC_W = (CFG_WIDTH_W > COL_W + 1) ? CFG_WIDTH_W : COL_W + 1;

  logic [CFG_WIDTH_W-1:0]  image_width;
  logic [CFG_HEIGHT_W-1:0] image_height;
  logic [COL_W-1:0]        column_count;
  logic [CFG_HEIGHT_W-1:0] row_count;

  logic [WC_W-1:0]         w_eff;
  logic [COL_W-1:0]        wm1;
  logic [CFG_HEIGHT_W-1:0] hm1;
  logic [COL_W-1:0]        col_eff;
  logic                    last_col;
  logic                    last_row;
  logic                    border_c;

  logic v1, v2, v3;
  logic ready1, ready2, ready3, ready_o;
  logic accept, ld_o;
  adv_t adv;

  pix_t s1_cur, s2_cur, s3_cur;
  pix_t s1_above;
  logic s1_border, s2_border, s3_border;
  pix_t left_pixel, upper_left_pixel;

  pval_t lane_mean [NUM_PRED];
  pval_t lane_pred [NUM_PRED][NUM_CH];

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // position in the image and border decision
  always_comb begin
    if (image_width == '0) begin
      w_eff = WC_W'(1);
    end else if (WC_W'(image_width) > WC_W'(MAX_WIDTH)) begin
      w_eff = WC_W'(MAX_WIDTH);
    end else begin
      w_eff = WC_W'(image_width);
    end
    wm1      = COL_W'(w_eff - WC_W'(1));
    hm1      = (image_height == '0) ? '0 : image_height - 1'b1;
    last_col = (column_count >= wm1);
    col_eff  = last_col ? wm1 : column_count;
    last_row = (row_count >= hm1);
    border_c = (row_count == '0) || last_row || (col_eff == '0) || last_col;
  end

  // pipeline handshake, a stage loads when it is empty or draining
  assign ready_o   = !pred_valid || !pred_stall;
  assign ready3    = !v3 || ready_o;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign accept    = pix_valid && ready1;
  assign pix_stall = !ready1;
  assign adv.ld2   = v1 && ready2;
  assign adv.ld3   = v2 && ready3;
  assign ld_o      = v3 && ready_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1               <= 1'b0;
      v2               <= 1'b0;
      v3               <= 1'b0;
      pred_valid       <= 1'b0;
      column_count     <= '0;
      row_count        <= '0;
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else begin
      if (ready1) begin
        v1 <= accept;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (ready_o) begin
        pred_valid <= v3;
      end
      if (accept) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + 1'b1;
        end else begin
          column_count <= col_eff + 1'b1;
        end
      end
      // neighbors move on as the word enters the lanes
      if (adv.ld2) begin
        left_pixel       <= s1_cur;
        upper_left_pixel <= s1_above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur    <= pix;
      s1_border <= border_c;
    end
    if (adv.ld2) begin
      s2_cur    <= s1_cur;
      s2_border <= s1_border;
    end
    if (adv.ld3) begin
      s3_cur    <= s2_cur;
      s3_border <= s2_border;
    end
  end

  lpms_row_mem u_row_mem (
    .clk   (clk),
    .en    (accept),
    .addr  (col_eff),
    .wdata (pix),
    .rdata (s1_above)
  );

  for (genvar i = 0; i < NUM_PRED; i++) begin : g_lane
    lpms_lane u_lane (
      .clk    (clk),
      .idx    (pred_sel_t'(3'(i))),
      .adv    (adv),
      .left   (left_pixel),
      .above  (s1_above),
      .upleft (upper_left_pixel),
      .pred   (lane_pred[i]),
      .mean   (lane_mean[i])
    );
  end

  lpms_merge u_merge (
    .clk    (clk),
    .ld     (ld_o),
    .cur    (s3_cur),
    .border (s3_border),
    .mean   (lane_mean),
    .pred   (lane_pred),
    .res    (pred)
  );

  `LPMS_ASSERT(a_enter, accept |=> v1, "accepted word did not enter the pipeline")
  `LPMS_ASSERT(a_hold3, v3 && !ready_o |=> v3 && $stable(s3_cur) && $stable(s3_border), "stage three changed while blocked")
  `LPMS_ASSERT(a_wrap, accept && last_col && last_row |=> column_count == '0 && row_count == '0, "counters did not wrap at end of image")
  `LPMS_ASSERT(a_out_load, ld_o |=> pred_valid, "loaded result word not presented")
  `LPMS_ASSERT_RST(a_rst_empty, rst |=> !pred_valid && !v1 && !v2 && !v3, "pipeline not empty after reset")

endmodule
